FILE: rtl/ascon_pkg.sv
// ----------------------------------------------------------------------------
// ASCON-128 engine package
// Shared types, item and register codes, sponge constants and the helper
// functions for round constants, byte masks and padding.
// ----------------------------------------------------------------------------
`default_nettype none

package ascon_pkg;

  typedef logic [4:0][63:0] sponge_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_AAD   = 2'd1,
    KIND_TEXT  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_AAD  = 2'd1,
    PH_TEXT = 2'd2,
    PH_NONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_DECRYPT  = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_index_e;

  localparam logic [63:0] ASCON_IV  = 64'h80400c0600000000;
  localparam logic [63:0] PAD_FULL  = 64'h8000000000000000;
  localparam logic [63:0] DOMAIN    = 64'h0000000000000001;
  localparam logic [3:0]  FULL_WORD = 4'd8;

  localparam logic [3:0] PA_FIRST   = 4'd0;
  localparam logic [3:0] PB_FIRST   = 4'd6;
  localparam logic [3:0] LAST_ROUND = 4'd11;

  function automatic logic [7:0] round_const(input logic [3:0] r);
    logic [3:0] hi;
    hi = 4'd15 - r;
    return {hi, r};
  endfunction

  function automatic logic [3:0] clamp_bytes(input logic [3:0] n);
    return (n > FULL_WORD) ? FULL_WORD : n;
  endfunction

  function automatic logic [63:0] top_mask(input logic [3:0] n);
    logic [63:0] ones;
    ones = '1;
    return n[3] ? ones : ~(ones >> {n[2:0], 3'b000});
  endfunction

  function automatic logic [63:0] pad_at(input logic [3:0] n);
    return n[3] ? 64'd0 : (PAD_FULL >> {n[2:0], 3'b000});
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ascon_round.sv
// ----------------------------------------------------------------------------
// ASCON permutation round
// One round of the permutation: constant addition, the 5-bit substitution
// layer across the five words and the linear diffusion of each word.
// ----------------------------------------------------------------------------
`default_nettype none

module perm_round
  import ascon_pkg::*;
(
  input  sponge_t    state_i,
  input  logic [7:0] rc_i,
  output sponge_t    state_o
);

  logic [63:0] a0, a1, a2, a3, a4;
  logic [63:0] s0, s1, s2, s3, s4;
  logic [63:0] t0, t1, t2, t3, t4;

  always_comb begin
    a0 = state_i[0] ^ state_i[4];
    a4 = state_i[4] ^ state_i[3];
    a2 = state_i[2] ^ {56'd0, rc_i} ^ state_i[1];
    a1 = state_i[1];
    a3 = state_i[3];

    s0 = a0 ^ (~a1 & a2);
    s1 = a1 ^ (~a2 & a3);
    s2 = a2 ^ (~a3 & a4);
    s3 = a3 ^ (~a4 & a0);
    s4 = a4 ^ (~a0 & a1);

    t1 = s1 ^ s0;
    t0 = s0 ^ s4;
    t3 = s3 ^ s2;
    t2 = ~s2;
    t4 = s4;

    state_o[0] = t0 ^ {t0[18:0], t0[63:19]} ^ {t0[27:0], t0[63:28]};
    state_o[1] = t1 ^ {t1[60:0], t1[63:61]} ^ {t1[38:0], t1[63:39]};
    state_o[2] = t2 ^ {t2[0],    t2[63:1]}  ^ {t2[5:0],  t2[63:6]};
    state_o[3] = t3 ^ {t3[9:0],  t3[63:10]} ^ {t3[16:0], t3[63:17]};
    state_o[4] = t4 ^ {t4[6:0],  t4[63:7]}  ^ {t4[40:0], t4[63:41]};
  end

endmodule

`default_nettype wire

FILE: rtl/ascon128_aead_engine_top.sv
// ----------------------------------------------------------------------------
// ASCON-128 AEAD engine
// Authenticated encryption and decryption over a 320-bit sponge, one 64-bit
// word per input word, driven by a small sequencer around one round unit.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o   kind, data, bytes, last, nonce,
//                                               expected tag
//   out      output     out_valid_o/out_ready_i text word, bytes, tag, flags
//   cfg      input      cfg_valid_i/cfg_ready_o register index and data
//
// One permutation round per cycle from the shared round unit; the input is not
// ready while a word is processed. A start word runs the initialization
// permutation, the last text word also runs the 12 finalization rounds, and a
// text word that closes the associated data first runs that closing. Reset
// clears the sponge, the phase and the output valid. A waiting result holds the
// sequencer only when the next result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon128_aead_engine_top
  import ascon_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  input  logic [63:0] nonce_high_i,
  input  logic [63:0] nonce_low_i,
  input  logic [63:0] expect_tag_high_i,
  input  logic [63:0] expect_tag_low_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_word_o,
  output logic [3:0]  out_bytes_o,
  output logic [63:0] tag_high_o,
  output logic [63:0] tag_low_o,
  output logic        tag_valid_o,
  output logic        auth_fail_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_PERM      = 4'd1;
  localparam logic [3:0] ST_INIT_FIN  = 4'd2;
  localparam logic [3:0] ST_CLOSE     = 4'd3;
  localparam logic [3:0] ST_CLOSE_PAD = 4'd4;
  localparam logic [3:0] ST_CLOSE_DOM = 4'd5;
  localparam logic [3:0] ST_TEXT      = 4'd6;
  localparam logic [3:0] ST_TEXT_PAD  = 4'd7;
  localparam logic [3:0] ST_FIN_KEY   = 4'd8;
  localparam logic [3:0] ST_FIN_TAG   = 4'd9;
  localparam logic [3:0] ST_EMIT      = 4'd10;

  logic [3:0]  state_q, state_d;
  logic [3:0]  cont_q, cont_d;
  logic [3:0]  rnd_q, rnd_d;
  sponge_t     x_q, x_d, x_rnd;
  phase_e      phase_q, phase_d;
  logic        aad_seen_q, aad_seen_d;

  logic [63:0] key_high_q, key_low_q;
  logic        decrypt_q;

  kind_e       itm_kind_q;
  logic [63:0] itm_data_q;
  logic [3:0]  itm_n_q;
  logic        itm_last_q;
  logic        itm_dec_q;
  logic [63:0] exp_high_q, exp_low_q;
  logic [63:0] word_q, word_d;

  logic        out_valid_q, out_valid_d;
  logic [63:0] out_word_q, out_tag_high_q, out_tag_low_q;
  logic [3:0]  out_bytes_q;
  logic        out_tag_valid_q, out_fail_q;

  logic        in_acc, out_free, emit;
  logic [3:0]  cl_n;
  logic [63:0] cl_data, cl_mask, cl_pad, tx_mask, tx_pad, x0_text;

  perm_round u_round (
    .state_i (x_q),
    .rc_i    (round_const(rnd_q)),
    .state_o (x_rnd)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = (state_q == ST_EMIT) && out_free;

  assign cl_n    = (itm_kind_q == KIND_TEXT) ? 4'd0 : itm_n_q;
  assign cl_data = (itm_kind_q == KIND_TEXT) ? 64'd0 : itm_data_q;
  assign cl_mask = top_mask(cl_n);
  assign cl_pad  = pad_at(cl_n);
  assign tx_mask = top_mask(itm_n_q);
  assign tx_pad  = pad_at(itm_n_q);

  always_comb begin
    state_d    = state_q;
    cont_d     = cont_q;
    rnd_d      = rnd_q;
    x_d        = x_q;
    phase_d    = phase_q;
    aad_seen_d = aad_seen_q;
    word_d     = word_q;
    x0_text    = x_q[0] ^ (itm_data_q & tx_mask) ^ tx_pad;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (kind_e'(kind_i) == KIND_START) begin
            x_d     = {nonce_low_i, nonce_high_i, key_low_q, key_high_q, ASCON_IV};
            rnd_d   = PA_FIRST;
            cont_d  = ST_INIT_FIN;
            state_d = ST_PERM;
          end else if (kind_e'(kind_i) == KIND_AAD && phase_q == PH_AAD) begin
            if (last_word_i) begin
              state_d = ST_CLOSE;
            end else begin
              x_d[0]     = x_q[0] ^ data_word_i;
              aad_seen_d = 1'b1;
              rnd_d      = PB_FIRST;
              cont_d     = ST_IDLE;
              state_d    = ST_PERM;
            end
          end else if (kind_e'(kind_i) == KIND_TEXT && phase_q == PH_AAD) begin
            state_d = ST_CLOSE;
          end else if (kind_e'(kind_i) == KIND_TEXT && phase_q == PH_TEXT) begin
            state_d = ST_TEXT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PERM: begin
        x_d = x_rnd;
        if (rnd_q == LAST_ROUND) begin
          state_d = cont_q;
        end else begin
          rnd_d = rnd_q + 4'd1;
        end
      end
      ST_INIT_FIN: begin
        x_d[3]     = x_q[3] ^ key_high_q;
        x_d[4]     = x_q[4] ^ key_low_q;
        phase_d    = PH_AAD;
        aad_seen_d = 1'b0;
        state_d    = ST_IDLE;
      end
      ST_CLOSE: begin
        if (cl_n != 4'd0 || aad_seen_q) begin
          x_d[0]  = x_q[0] ^ (cl_data & cl_mask) ^ cl_pad;
          rnd_d   = PB_FIRST;
          cont_d  = (cl_n == FULL_WORD) ? ST_CLOSE_PAD : ST_CLOSE_DOM;
          state_d = ST_PERM;
        end else begin
          state_d = ST_CLOSE_DOM;
        end
      end
      ST_CLOSE_PAD: begin
        x_d[0]  = x_q[0] ^ PAD_FULL;
        rnd_d   = PB_FIRST;
        cont_d  = ST_CLOSE_DOM;
        state_d = ST_PERM;
      end
      ST_CLOSE_DOM: begin
        x_d[4]  = x_q[4] ^ DOMAIN;
        phase_d = PH_TEXT;
        state_d = (itm_kind_q == KIND_TEXT) ? ST_TEXT : ST_IDLE;
      end
      ST_TEXT: begin
        if (itm_dec_q) begin
          word_d = (x_q[0] ^ itm_data_q) & tx_mask;
          x_d[0] = ((x_q[0] & ~tx_mask) | (itm_data_q & tx_mask)) ^ tx_pad;
        end else begin
          word_d = x0_text & tx_mask;
          x_d[0] = x0_text;
        end
        if (itm_n_q == FULL_WORD) begin
          rnd_d   = PB_FIRST;
          cont_d  = ST_TEXT_PAD;
          state_d = ST_PERM;
        end else begin
          state_d = ST_FIN_KEY;
        end
      end
      ST_TEXT_PAD: begin
        if (itm_last_q) begin
          x_d[0]  = x_q[0] ^ PAD_FULL;
          state_d = ST_FIN_KEY;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_FIN_KEY: begin
        x_d[1]  = x_q[1] ^ key_high_q;
        x_d[2]  = x_q[2] ^ key_low_q;
        rnd_d   = PA_FIRST;
        cont_d  = ST_FIN_TAG;
        state_d = ST_PERM;
      end
      ST_FIN_TAG: begin
        x_d[3]  = x_q[3] ^ key_high_q;
        x_d[4]  = x_q[4] ^ key_low_q;
        phase_d = PH_IDLE;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cont_q      <= ST_IDLE;
      rnd_q       <= PA_FIRST;
      x_q         <= '0;
      phase_q     <= PH_IDLE;
      aad_seen_q  <= 1'b0;
      key_high_q  <= '0;
      key_low_q   <= '0;
      decrypt_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cont_q      <= cont_d;
      rnd_q       <= rnd_d;
      x_q         <= x_d;
      phase_q     <= phase_d;
      aad_seen_q  <= aad_seen_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_KEY_HIGH: key_high_q <= cfg_data_i;
          CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
          CFG_DECRYPT:  decrypt_q  <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (in_acc) begin
      itm_kind_q <= kind_e'(kind_i);
      itm_data_q <= data_word_i;
      itm_n_q    <= last_word_i ? clamp_bytes(byte_count_i) : FULL_WORD;
      itm_last_q <= last_word_i;
      itm_dec_q  <= decrypt_q;
      exp_high_q <= expect_tag_high_i;
      exp_low_q  <= expect_tag_low_i;
    end
    if (emit) begin
      out_word_q      <= word_q;
      out_bytes_q     <= itm_n_q;
      out_tag_valid_q <= itm_last_q;
      out_tag_high_q  <= itm_last_q ? x_q[3] : 64'd0;
      out_tag_low_q   <= itm_last_q ? x_q[4] : 64'd0;
      out_fail_q      <= itm_last_q && itm_dec_q &&
                         (x_q[3] != exp_high_q || x_q[4] != exp_low_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_bytes_o = out_bytes_q;
  assign tag_high_o  = out_tag_high_q;
  assign tag_low_o   = out_tag_low_q;
  assign tag_valid_o = out_tag_valid_q;
  assign auth_fail_o = out_fail_q;

endmodule

`default_nettype wire

FILE: rtl/ascon_chk.sv
// ----------------------------------------------------------------------------
// ASCON-128 engine port checker
// Concurrent checks on the top-level ports, attached to the top by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon_chk
  import ascon_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  kind_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] out_word_o,
  input logic [3:0]  out_bytes_o,
  input logic [63:0] tag_high_o,
  input logic [63:0] tag_low_o,
  input logic        tag_valid_o,
  input logic        auth_fail_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("Output word changed while stalled.");

  a_fail_on_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && auth_fail_o |-> tag_valid_o)
    else $error("Authentication failure flagged on a word without a tag.");

  a_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tag_valid_o |->
      out_bytes_o == FULL_WORD && tag_high_o == 64'd0 && tag_low_o == 64'd0)
    else $error("Non-final word is partial or carries a tag.");

  a_bytes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_bytes_o <= FULL_WORD)
    else $error("Output byte count out of range.");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_START |=> !in_ready_o)
    else $error("Input ready right after a start word.");

endmodule

bind ascon128_aead_engine_top ascon_chk u_ascon_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o),
  .out_bytes_o (out_bytes_o),
  .tag_high_o  (tag_high_o),
  .tag_low_o   (tag_low_o),
  .tag_valid_o (tag_valid_o),
  .auth_fail_o (auth_fail_o)
);

`default_nettype wire

FILE: tb/ascon128_aead_engine_top_test.sv
// ----------------------------------------------------------------------------
// ASCON-128 AEAD engine test
// Drives start, associated-data and text words into the engine, and writes
// its key and mode registers. A sponge predictor in the bench computes each
// text word and tag, and every output word is compared with the oldest
// prediction. Decryption traffic is built by sealing the plaintext with the
// predictor first, and some of the tags are then corrupted on purpose.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ascon128_aead_engine_top_test;
  import ascon_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int PHASE_ITEMS   = 250;

  typedef struct packed {
    sponge_t    s;
    phase_e     phase;
    logic       aad_seen;
  } engine_t;

  typedef struct packed {
    logic [63:0] key_h;
    logic [63:0] key_l;
    logic        dec;
  } keycfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic [63:0] nonce_h;
    logic [63:0] nonce_l;
    logic [63:0] tag_h;
    logic [63:0] tag_l;
  } word_t;

  typedef struct packed {
    logic [63:0] text;
    logic [3:0]  nbytes;
    logic [63:0] tag_h;
    logic [63:0] tag_l;
    logic        tag_valid;
    logic        auth_fail;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_NONE;
  logic [63:0] data_word_i = '0;
  logic [3:0]  byte_count_i = '0;
  logic        last_word_i = 1'b0;
  logic [63:0] nonce_high_i = '0;
  logic [63:0] nonce_low_i = '0;
  logic [63:0] expect_tag_high_i = '0;
  logic [63:0] expect_tag_low_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] out_word_o;
  logic [3:0]  out_bytes_o;
  logic [63:0] tag_high_o;
  logic [63:0] tag_low_o;
  logic        tag_valid_o;
  logic        auth_fail_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_KEY_HIGH;
  logic [63:0] cfg_data_i = '0;

  engine_t engine_state = '0;
  keycfg_t key_regs = '0;
  result_t due_text_words[$];
  word_t   script[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      burst_left = 0;
  bit      steady_feed = 1'b0;
  int      quiet_cycles = 0;
  logic [15:0] rx_tick = '0;

  ascon128_aead_engine_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .last_word_i      (last_word_i),
    .nonce_high_i     (nonce_high_i),
    .nonce_low_i      (nonce_low_i),
    .expect_tag_high_i(expect_tag_high_i),
    .expect_tag_low_i (expect_tag_low_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_word_o       (out_word_o),
    .out_bytes_o      (out_bytes_o),
    .tag_high_o       (tag_high_o),
    .tag_low_o        (tag_low_o),
    .tag_valid_o      (tag_valid_o),
    .auth_fail_o      (auth_fail_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [63:0] ror64(logic [63:0] v, int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic sponge_t sponge_round(sponge_t x, logic [7:0] rc);
    logic [63:0] a0, a1, a2, a3, a4;
    logic [63:0] b0, b1, b2, b3, b4;
    sponge_t y;
    a0 = x[0] ^ x[4];
    a1 = x[1];
    a2 = x[2] ^ {56'd0, rc} ^ x[1];
    a3 = x[3];
    a4 = x[4] ^ x[3];
    b0 = a0 ^ (~a1 & a2);
    b1 = a1 ^ (~a2 & a3);
    b2 = a2 ^ (~a3 & a4);
    b3 = a3 ^ (~a4 & a0);
    b4 = a4 ^ (~a0 & a1);
    b1 = b1 ^ b0;
    b0 = b0 ^ b4;
    b3 = b3 ^ b2;
    b2 = ~b2;
    y[0] = b0 ^ ror64(b0, 19) ^ ror64(b0, 28);
    y[1] = b1 ^ ror64(b1, 61) ^ ror64(b1, 39);
    y[2] = b2 ^ ror64(b2, 1) ^ ror64(b2, 6);
    y[3] = b3 ^ ror64(b3, 10) ^ ror64(b3, 17);
    y[4] = b4 ^ ror64(b4, 7) ^ ror64(b4, 41);
    return y;
  endfunction

  function automatic sponge_t sponge_permute(sponge_t x, logic [3:0] first);
    logic [7:0] rc;
    for (int r = int'(first); r < 12; r++) begin
      rc = 8'(((15 - r) << 4) | r);
      x = sponge_round(x, rc);
    end
    return x;
  endfunction

  function automatic logic [63:0] lane_mask(logic [3:0] n);
    return (n >= FULL_WORD) ? {64{1'b1}} : ~({64{1'b1}} >> (8 * n));
  endfunction

  function automatic logic [63:0] pad_marker(logic [3:0] n);
    return 64'h80 << (56 - 8 * n);
  endfunction

  function automatic engine_t close_assoc(engine_t e, logic [63:0] data, logic [3:0] n);
    sponge_t x;
    x = e.s;
    if (n == FULL_WORD) begin
      x[0] = x[0] ^ data;
      x = sponge_permute(x, PB_FIRST);
      x[0] = x[0] ^ PAD_FULL;
      x = sponge_permute(x, PB_FIRST);
    end else if (n != 4'd0 || e.aad_seen) begin
      x[0] = x[0] ^ (data & lane_mask(n)) ^ pad_marker(n);
      x = sponge_permute(x, PB_FIRST);
    end
    x[4] = x[4] ^ DOMAIN;
    e.s = x;
    e.phase = PH_TEXT;
    return e;
  endfunction

  task automatic ascon_step(inout engine_t e, input keycfg_t k, input word_t w,
                            output result_t r, output bit has);
    sponge_t x;
    logic [3:0] n;
    logic [63:0] m, txt, th, tl;
    has = 1'b0;
    r = '0;
    th = '0;
    tl = '0;
    txt = '0;
    n = (w.nbytes > FULL_WORD) ? FULL_WORD : w.nbytes;
    case (w.kind)
      KIND_START: begin
        x[0] = ASCON_IV;
        x[1] = k.key_h;
        x[2] = k.key_l;
        x[3] = w.nonce_h;
        x[4] = w.nonce_l;
        x = sponge_permute(x, PA_FIRST);
        x[3] = x[3] ^ k.key_h;
        x[4] = x[4] ^ k.key_l;
        e.s = x;
        e.phase = PH_AAD;
        e.aad_seen = 1'b0;
      end
      KIND_AAD: begin
        if (e.phase == PH_AAD) begin
          if (w.last) begin
            e = close_assoc(e, w.data, n);
          end else begin
            x = e.s;
            x[0] = x[0] ^ w.data;
            e.s = sponge_permute(x, PB_FIRST);
            e.aad_seen = 1'b1;
          end
        end
      end
      KIND_TEXT: begin
        if (e.phase == PH_AAD) e = close_assoc(e, '0, '0);
        if (e.phase == PH_TEXT) begin
          x = e.s;
          if (!w.last) n = FULL_WORD;
          if (n == FULL_WORD) begin
            if (k.dec) begin
              txt = x[0] ^ w.data;
              x[0] = w.data;
            end else begin
              x[0] = x[0] ^ w.data;
              txt = x[0];
            end
            x = sponge_permute(x, PB_FIRST);
            if (w.last) x[0] = x[0] ^ PAD_FULL;
          end else begin
            m = lane_mask(n);
            if (k.dec) begin
              txt = (x[0] ^ w.data) & m;
              x[0] = ((x[0] & ~m) | (w.data & m)) ^ pad_marker(n);
            end else begin
              x[0] = x[0] ^ (w.data & m) ^ pad_marker(n);
              txt = x[0] & m;
            end
          end
          if (w.last) begin
            x[1] = x[1] ^ k.key_h;
            x[2] = x[2] ^ k.key_l;
            x = sponge_permute(x, PA_FIRST);
            x[3] = x[3] ^ k.key_h;
            x[4] = x[4] ^ k.key_l;
            th = x[3];
            tl = x[4];
            r.auth_fail = k.dec && (th != w.tag_h || tl != w.tag_l);
            e.phase = PH_IDLE;
          end
          e.s = x;
          r.text = txt;
          r.nbytes = n;
          r.tag_h = th;
          r.tag_l = tl;
          r.tag_valid = w.last;
          has = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [63:0] random_lane();
    logic [63:0] v;
    case ($urandom_range(0, 15))
      0: v = '0;
      1: v = '1;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [3:0] last_count();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
  endfunction

  function automatic word_t make_word(kind_e k, logic last, logic [3:0] n);
    word_t w;
    w.kind = k;
    w.last = last;
    w.nbytes = n;
    w.data = random_lane();
    w.nonce_h = random_lane();
    w.nonce_l = random_lane();
    w.tag_h = random_lane();
    w.tag_l = random_lane();
    return w;
  endfunction

  task automatic queue_word(kind_e k, logic last, logic [3:0] n, logic [63:0] data);
    word_t w;
    w = make_word(k, last, n);
    w.data = data;
    script.push_back(w);
  endtask

  task automatic queue_start(logic [63:0] nh, logic [63:0] nl);
    word_t w;
    w = make_word(KIND_START, 1'b0, 4'd0);
    w.nonce_h = nh;
    w.nonce_l = nl;
    script.push_back(w);
  endtask

  task automatic send_word(word_t w);
    result_t r;
    bit has;
    int gap;
    if (burst_left == 0) begin
      gap = (steady_feed || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    kind_i <= w.kind;
    data_word_i <= w.data;
    byte_count_i <= w.nbytes;
    last_word_i <= w.last;
    nonce_high_i <= w.nonce_h;
    nonce_low_i <= w.nonce_l;
    expect_tag_high_i <= w.tag_h;
    expect_tag_low_i <= w.tag_l;
    do @(posedge clk_i); while (!in_ready_o);
    ascon_step(engine_state, key_regs, w, r, has);
    if (has) due_text_words.push_back(r);
    if (w.kind != KIND_NONE) items_sent++;
  endtask

  // In decrypt mode the script is first sealed with a copy of the sponge so
  // that the text words carry real ciphertext and the tags are genuine unless corrupt is set.
  task automatic send_script(bit corrupt);
    engine_t trial;
    keycfg_t seal_regs;
    result_t r;
    bit has;
    word_t w;
    logic [127:0] flip;
    if (key_regs.dec) begin
      trial = engine_state;
      seal_regs = key_regs;
      seal_regs.dec = 1'b0;
      for (int i = 0; i < script.size(); i++) begin
        w = script[i];
        ascon_step(trial, seal_regs, w, r, has);
        if (has) begin
          w.data = r.text | (w.data & ~lane_mask(r.nbytes));
          if (r.tag_valid) begin
            flip = corrupt ? (128'd1 << $urandom_range(0, 127)) : '0;
            w.tag_h = r.tag_h ^ flip[127:64];
            w.tag_l = r.tag_l ^ flip[63:0];
          end
          script[i] = w;
        end
      end
    end
    for (int i = 0; i < script.size(); i++) send_word(script[i]);
    script.delete();
  endtask

  task automatic wait_engine_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (due_text_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [63:0] value);
    wait_engine_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_KEY_HIGH: key_regs.key_h = value;
      CFG_KEY_LOW:  key_regs.key_l = value;
      CFG_DECRYPT:  key_regs.dec = value[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    queue_word(KIND_TEXT, 1'b1, 4'd8, '1);
    queue_word(KIND_AAD, 1'b1, 4'd3, '1);
    queue_word(KIND_NONE, 1'b1, 4'd15, '1);
    queue_start('1, '1);
    queue_word(KIND_AAD, 1'b1, 4'd0, '1);
    queue_word(KIND_TEXT, 1'b1, 4'd0, '1);
    send_script(1'b0);
  endtask

  task automatic test_edge_messages();
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_UNUSED, random_lane());
    queue_start('0, '0);
    queue_word(KIND_AAD, 1'b0, 4'd15, '1);
    queue_word(KIND_AAD, 1'b1, 4'd8, '0);
    queue_word(KIND_TEXT, 1'b0, 4'd2, '1);
    queue_word(KIND_TEXT, 1'b1, 4'd8, '0);
    queue_start(random_lane(), random_lane());
    queue_word(KIND_AAD, 1'b0, 4'd8, random_lane());
    queue_word(KIND_AAD, 1'b1, 4'd0, random_lane());
    queue_word(KIND_TEXT, 1'b1, 4'd15, '1);
    queue_start(random_lane(), random_lane());
    queue_word(KIND_TEXT, 1'b1, 4'd5, '1);
    queue_start(random_lane(), random_lane());
    queue_word(KIND_AAD, 1'b0, 4'd7, random_lane());
    queue_start(random_lane(), random_lane());
    queue_word(KIND_TEXT, 1'b1, 4'd1, random_lane());
    send_script(1'b0);
  endtask

  task automatic test_key_swap_mid_message();
    queue_start(random_lane(), random_lane());
    queue_word(KIND_AAD, 1'b0, 4'd8, random_lane());
    send_script(1'b0);
    write_reg(CFG_KEY_LOW, random_lane());
    write_reg(CFG_KEY_HIGH, random_lane());
    queue_word(KIND_TEXT, 1'b1, 4'd4, random_lane());
    send_script(1'b0);
  endtask

  task automatic test_decrypt_tags();
    write_reg(CFG_DECRYPT, 64'd1);
    for (int i = 0; i < 2; i++) begin
      queue_start(random_lane(), random_lane());
      queue_word(KIND_AAD, 1'b1, 4'd3, random_lane());
      queue_word(KIND_TEXT, 1'b1, 4'd7, random_lane());
      send_script(i == 1);
    end
  endtask

  task automatic send_random_message();
    word_t w;
    int n_aad, n_text;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: w = make_word(KIND_NONE, 1'($urandom), 4'($urandom));
        1: w = make_word(KIND_AAD, 1'($urandom), 4'($urandom));
        default: w = make_word(KIND_TEXT, 1'($urandom), 4'($urandom));
      endcase
      script.push_back(w);
    end
    script.push_back(make_word(KIND_START, 1'($urandom), 4'($urandom)));
    n_aad = $urandom_range(0, 3);
    for (int i = 0; i < n_aad; i++) script.push_back(make_word(KIND_AAD, 1'b0, 4'($urandom)));
    if ($urandom_range(0, 3) != 0) script.push_back(make_word(KIND_AAD, 1'b1, last_count()));
    n_text = $urandom_range(1, 5);
    for (int i = 1; i < n_text; i++) begin
      script.push_back(make_word(KIND_TEXT, 1'b0, 4'($urandom)));
      if ($urandom_range(0, 15) == 0) script.push_back(make_word(KIND_AAD, 1'b1, last_count()));
    end
    if ($urandom_range(0, 24) != 0) script.push_back(make_word(KIND_TEXT, 1'b1, last_count()));
    send_script($urandom_range(0, 3) == 0);
  endtask

  task automatic test_random_traffic();
    int stop_at, phase_end, phase_no;
    logic [63:0] kh, kl;
    stop_at = items_sent + RANDOM_ITEMS;
    phase_no = 0;
    while (items_sent < stop_at) begin
      case (phase_no % 4)
        0: begin
          kh = '1;
          kl = '0;
        end
        1: begin
          kh = '0;
          kl = '1;
        end
        default: begin
          kh = random_lane();
          kl = random_lane();
        end
      endcase
      write_reg(CFG_KEY_HIGH, kh);
      write_reg(CFG_KEY_LOW, kl);
      write_reg(CFG_DECRYPT, {63'(random_lane() >> 1), 1'(phase_no)});
      steady_feed = (phase_no % 3 == 2);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < stop_at) send_random_message();
      phase_no++;
    end
    steady_feed = 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_text_words.size() == 0) begin
        $error("output word with no prediction waiting: out_word %h", out_word_o);
        mismatches++;
      end else begin
        r = due_text_words.pop_front();
        check_field("out_word", r.text, out_word_o);
        check_field("out_bytes", 64'(r.nbytes), 64'(out_bytes_o));
        check_field("tag_high", r.tag_h, tag_high_o);
        check_field("tag_low", r.tag_l, tag_low_o);
        check_field("tag_valid", 64'(r.tag_valid), 64'(tag_valid_o));
        check_field("auth_fail", 64'(r.auth_fail), 64'(auth_fail_o));
      end
    end
  end

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 16'd1;
    case (rx_tick[10:9])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready_i <= (rx_tick[3:0] == 4'd0) || (rx_tick[3:0] == 4'd9);
      default: out_ready_i <= 1'($urandom);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("ascon128_aead_engine_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_edge_messages();
    test_key_swap_mid_message();
    test_decrypt_tags();
    test_random_traffic();
    wait_engine_idle();
    if (mismatches == 0 && due_text_words.size() == 0) begin
      $display("ascon128_aead_engine_top verification clean");
    end else begin
      $display("ascon128_aead_engine_top verification failed");
    end
    $finish;
  end

endmodule
